### sv/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg
// Shared sizes, register indexes and controller/datapath interface types
// for the chord sequence capture block.
// ----------------------------------------------------------------------------
package csc_pkg;

   // Number of buttons and depth of the text store.
   localparam int BUTTONS   = 16;
   localparam int MAX_LEN   = 32;

   localparam int BTN_IDX_W = $clog2(BUTTONS);
   localparam int BTN_CNT_W = $clog2(BUTTONS + 1);
   localparam int ADDR_W    = $clog2(MAX_LEN);
   localparam int LEN_W     = $clog2(MAX_LEN + 1);

   localparam int CHAR_W    = 8;
   localparam int ELAPSED_W = 16;
   localparam int IDLE_W    = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINK_SYMBOL  = 3'd0,
      CSR_SYMBOLS_LOW  = 3'd1,
      CSR_SYMBOLS_HIGH = 3'd2,
      CSR_TIMEOUT      = 3'd3,
      CSR_MAX_LENGTH   = 3'd4,
      CSR_BUTTON_COUNT = 3'd5
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // take a new item, restart the scan
      logic put_link;    // append the link symbol
      logic put_symbol;  // append the current button's symbol and advance
      logic skip;        // no press on the current button, advance
      logic idle_update; // fold the tick into the idle time
      logic read_char;   // fetch the next character of the release
      logic next_char;   // step the release pointer
      logic clear_text;  // empty the store after the last character
   } csc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;   // all buttons scanned or length limit reached
      logic press_edge;  // current button has a rising edge
      logic pressed;     // a press was already collected in this tick
      logic release_ok;  // idle time exceeds timeout and store not empty
      logic last_char;   // fetched character is the final one
   } csc_status_type;

endpackage

### sv/csc_ctrl.sv
// ----------------------------------------------------------------------------
// csc_ctrl
// Controller state machine: sequences the button scan, the idle time update
// and the character-by-character release of the collected text.
// ----------------------------------------------------------------------------
module csc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    rsp_ready,
   input  csc_pkg::csc_status_type status,
   output csc_pkg::csc_cmd_type    cmd,
   output logic                    req_ready,
   output logic                    rsp_valid
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SCAN   = 7'b0000010,
      ST_SYMBOL = 7'b0000100,
      ST_UPDATE = 7'b0001000,
      ST_DECIDE = 7'b0010000,
      ST_READ   = 7'b0100000,
      ST_SHOW   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_UPDATE;
            end else if (status.press_edge && status.pressed) begin
               cmd.put_link = 1'b1;
               state_in     = ST_SYMBOL;
            end else if (status.press_edge) begin
               cmd.put_symbol = 1'b1;
            end else begin
               cmd.skip = 1'b1;
            end
         end
         ST_SYMBOL: begin
            // The symbol after a link goes in without a new limit check.
            cmd.put_symbol = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_UPDATE: begin
            cmd.idle_update = 1'b1;
            state_in        = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.release_ok) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.read_char = 1'b1;
            state_in      = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_ready) begin
               if (status.last_char) begin
                  cmd.clear_text = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  cmd.next_char = 1'b1;
                  state_in      = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_SHOW);

endmodule

### sv/csc_datapath.sv
// ----------------------------------------------------------------------------
// csc_datapath
// Configuration registers, item registers, button edge detection, text store
// and saturating idle time counter.
// ----------------------------------------------------------------------------
module csc_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [csc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [csc_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  logic [csc_pkg::BUTTONS-1:0]          req_levels,
   input  logic [csc_pkg::ELAPSED_W-1:0]        req_elapsed,
   input  csc_pkg::csc_cmd_type                 cmd,
   output csc_pkg::csc_status_type              status,
   output logic [csc_pkg::CHAR_W-1:0]           rsp_character,
   output logic                                 rsp_last
);

   // Configuration registers.
   logic [csc_pkg::CHAR_W-1:0]     link_symbol_ff;
   logic [63:0]                    symbols_low_ff;
   logic [63:0]                    symbols_high_ff;
   logic [csc_pkg::IDLE_W-1:0]     timeout_ff;
   logic [5:0]                     max_length_ff;
   logic [4:0]                     button_count_ff;

   // Item and scan state.
   logic [csc_pkg::BUTTONS-1:0]    levels_ff;
   logic [csc_pkg::ELAPSED_W-1:0]  elapsed_ff;
   logic [csc_pkg::BUTTONS-1:0]    prev_levels_ff;
   logic [csc_pkg::BUTTONS-1:0]    prev_levels_in;
   logic [csc_pkg::BTN_CNT_W-1:0]  button_ff;
   logic                           pressed_ff;
   logic [csc_pkg::LEN_W-1:0]      length_ff;
   logic [csc_pkg::IDLE_W-1:0]     idle_ff;
   logic [csc_pkg::ADDR_W-1:0]     read_ptr_ff;

   // Text store and its registered read port.
   logic [csc_pkg::CHAR_W-1:0]     text_store [csc_pkg::MAX_LEN];
   logic [csc_pkg::CHAR_W-1:0]     read_data_ff;
   logic                           read_last_ff;

   logic [csc_pkg::BTN_IDX_W-1:0]  button_idx;
   logic [csc_pkg::BTN_CNT_W-1:0]  count_eff;
   logic [csc_pkg::LEN_W-1:0]      limit_eff;
   logic [127:0]                   symbol_bits;
   logic [csc_pkg::CHAR_W-1:0]     symbol;
   logic                           store_write;
   logic [csc_pkg::CHAR_W-1:0]     store_data;
   logic [csc_pkg::IDLE_W:0]       idle_sum;
   logic [csc_pkg::IDLE_W-1:0]     idle_in;
   logic                           advance;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         link_symbol_ff  <= 8'd43;
         symbols_low_ff  <= '0;
         symbols_high_ff <= '0;
         timeout_ff      <= 32'd1000;
         max_length_ff   <= 6'd32;
         button_count_ff <= 5'd16;
      end else if (csr_write_enable) begin
         case (csr_index)
            csc_pkg::CSR_LINK_SYMBOL:  link_symbol_ff  <= csr_write_data[7:0];
            csc_pkg::CSR_SYMBOLS_LOW:  symbols_low_ff  <= csr_write_data;
            csc_pkg::CSR_SYMBOLS_HIGH: symbols_high_ff <= csr_write_data;
            csc_pkg::CSR_TIMEOUT:      timeout_ff      <= csr_write_data[31:0];
            csc_pkg::CSR_MAX_LENGTH:   max_length_ff   <= csr_write_data[5:0];
            csc_pkg::CSR_BUTTON_COUNT: button_count_ff <= csr_write_data[4:0];
            default: begin
            end
         endcase
      end
   end

   // Clamped scan bounds.
   assign count_eff = (button_count_ff > 5'(csc_pkg::BUTTONS))
                    ? csc_pkg::BTN_CNT_W'(csc_pkg::BUTTONS)
                    : csc_pkg::BTN_CNT_W'(button_count_ff);
   assign limit_eff = (max_length_ff > 6'(csc_pkg::MAX_LEN))
                    ? csc_pkg::LEN_W'(csc_pkg::MAX_LEN)
                    : csc_pkg::LEN_W'(max_length_ff);

   // Current button, its edge and its symbol.
   assign button_idx  = button_ff[csc_pkg::BTN_IDX_W-1:0];
   assign symbol_bits = {symbols_high_ff, symbols_low_ff};
   assign symbol      = symbol_bits[{button_idx, 3'b000} +: 8];

   assign status.scan_done  = (button_ff >= count_eff) || (length_ff >= limit_eff);
   assign status.press_edge = levels_ff[button_idx] && !prev_levels_ff[button_idx];
   assign status.pressed    = pressed_ff;
   assign status.release_ok = (idle_ff > timeout_ff) && (length_ff != '0);
   assign status.last_char  = read_last_ff;

   // A character that finds the store full is dropped.
   assign store_write = (cmd.put_link || cmd.put_symbol) &&
                        (length_ff < csc_pkg::LEN_W'(csc_pkg::MAX_LEN));
   assign store_data  = cmd.put_link ? link_symbol_ff : symbol;
   assign advance     = cmd.put_symbol || cmd.skip;

   // The scanned button takes its new level; others keep theirs.
   always_comb begin
      prev_levels_in = prev_levels_ff;
      if (advance) begin
         prev_levels_in[button_idx] = levels_ff[button_idx];
      end
   end

   // Saturating idle time; any press clears it.
   assign idle_sum = {1'b0, idle_ff} + {17'd0, elapsed_ff};
   assign idle_in  = pressed_ff ? '0
                   : (idle_sum[csc_pkg::IDLE_W] ? '1 : idle_sum[csc_pkg::IDLE_W-1:0]);

   // Control state of the datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_levels_ff <= '0;
         button_ff      <= '0;
         pressed_ff     <= 1'b0;
         length_ff      <= '0;
         idle_ff        <= '0;
         read_ptr_ff    <= '0;
      end else begin
         prev_levels_ff <= prev_levels_in;
         if (cmd.load) begin
            button_ff   <= '0;
            pressed_ff  <= 1'b0;
            read_ptr_ff <= '0;
         end
         if (advance) begin
            button_ff <= button_ff + 1'b1;
         end
         if (cmd.put_symbol) begin
            pressed_ff <= 1'b1;
         end
         if (store_write) begin
            length_ff <= length_ff + 1'b1;
         end
         if (cmd.idle_update) begin
            idle_ff <= idle_in;
         end
         if (cmd.next_char) begin
            read_ptr_ff <= read_ptr_ff + 1'b1;
         end
         if (cmd.clear_text) begin
            length_ff   <= '0;
            read_ptr_ff <= '0;
         end
      end
   end

   // Item payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         levels_ff  <= req_levels;
         elapsed_ff <= req_elapsed;
      end
   end

   // Text store: one write and one registered read.
   always_ff @(posedge clock) begin
      if (store_write) begin
         text_store[length_ff[csc_pkg::ADDR_W-1:0]] <= store_data;
      end
      if (cmd.read_char) begin
         read_data_ff <= text_store[read_ptr_ff];
         read_last_ff <= ({1'b0, read_ptr_ff} + 1'b1) == length_ff;
      end
   end

   assign rsp_character = read_data_ff;
   assign rsp_last      = read_last_ff;

endmodule

### sv/chord_sequence_capture_top.sv
// From acceptance the controller scans the buttons (the clamped button_count, fewer once
// the length limit is reached), with a symbol state after each link, then updates the
// idle time and decides on a release; with no release the next item is accepted in the
// cycle after the decision. A release reads each character from the store, then offers it
// until rsp_ready; the next item is accepted in the cycle after the last character.
// Reset (synchronous, active high) restores registers, levels and idle time; text emptied.
// ----------------------------------------------------------------------------
// chord_sequence_capture_top
// Collects newly pressed buttons into a short text and releases that text one
// character per result after a period without a new press.
// ----------------------------------------------------------------------------
module chord_sequence_capture_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [csc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [csc_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [csc_pkg::BUTTONS-1:0]        req_levels,
   input  logic [csc_pkg::ELAPSED_W-1:0]      req_elapsed,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [csc_pkg::CHAR_W-1:0]         rsp_character,
   output logic                               rsp_last
);

   csc_pkg::csc_cmd_type    cmd;
   csc_pkg::csc_status_type status;

   // Controller.
   csc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid)
   );

   // Datapath.
   csc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_levels       (req_levels),
      .req_elapsed      (req_elapsed),
      .cmd              (cmd),
      .status           (status),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last)
   );

   // A result is never offered while a new item can be taken.
   assert property (@(posedge clock) disable iff (reset) !(rsp_valid && req_ready))
      else $error("result offered while accepting items");

   // Taking the final character of a release frees the input side.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready)
      else $error("block not ready after final character");

   // An accepted item always starts a scan.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("accepted item did not start a scan");

   // No character is collected and no item is taken while a result is offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(cmd.load || cmd.put_link || cmd.put_symbol))
      else $error("text changed during a release");

endmodule
